>>> rtl/rpp_pkg.sv
package rpp_pkg;

    // Field and datapath widths
    localparam int COORD_W    = 16;
    localparam int TRIG_W     = 16;
    localparam int SCALE_W    = 16;
    localparam int PIXEL_W    = 8;
    localparam int ROT_W      = 24;
    localparam int PROD_W     = ROT_W + TRIG_W;
    localparam int WIDE_W     = 48;
    localparam int PIX_W      = 24;
    localparam int TRIG_SHIFT = 14;
    localparam int PIX_SHIFT  = 19;

    // Configuration register indexes
    localparam logic [2:0] REG_COS_YAW     = 3'd0;
    localparam logic [2:0] REG_SIN_YAW     = 3'd1;
    localparam logic [2:0] REG_COS_TILT    = 3'd2;
    localparam logic [2:0] REG_SIN_TILT    = 3'd3;
    localparam logic [2:0] REG_COS_ROLL    = 3'd4;
    localparam logic [2:0] REG_SIN_ROLL    = 3'd5;
    localparam logic [2:0] REG_PIXEL_SCALE = 3'd6;

    // Reset values
    localparam logic [TRIG_W-1:0]  TRIG_ONE    = 16'd16384;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic [PIXEL_W-1:0] screen_x;
        logic [PIXEL_W-1:0] screen_y;
        logic               visible;
    } t_screen;

    // Arithmetic shift right by s, rounding half away from zero
    function automatic logic signed [WIDE_W-1:0] rnd_shr(
        input logic signed [WIDE_W-1:0] v,
        input logic [5:0]               s
    );
        logic signed [WIDE_W-1:0] half;
        logic signed [WIDE_W-1:0] biased;
        half = $signed(48'd1 << (s - 6'd1));
        if (v[WIDE_W-1]) begin
            biased = v + half - 48'sd1;
        end else begin
            biased = v + half;
        end
        return biased >>> s;
    endfunction

endpackage

>>> rtl/rpp_rot.sv
module rpp_rot
    import rpp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic                    i_sub,
    input  logic signed [ROT_W-1:0] i_a,
    input  logic signed [TRIG_W-1:0] i_b,
    input  logic signed [ROT_W-1:0] i_c,
    input  logic signed [TRIG_W-1:0] i_d,
    output logic                    o_vld,
    output logic signed [ROT_W-1:0] o_res
);

    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] n_p0;
    logic signed [PROD_W-1:0] n_p1;
    logic                     r_sub;
    logic                     r_vld1;
    logic                     r_vld2;
    logic signed [ROT_W-1:0]  r_res;
    logic signed [ROT_W-1:0]  n_res;
    logic signed [WIDE_W-1:0] w_sum;
    logic signed [WIDE_W-1:0] w_rnd;

    // Form both products
    assign n_p0 = i_a * i_b;
    assign n_p1 = i_c * i_d;

    // Combine and round back to Q.11
    always_comb begin
        if (r_sub) begin
            w_sum = WIDE_W'(r_p0) - WIDE_W'(r_p1);
        end else begin
            w_sum = WIDE_W'(r_p0) + WIDE_W'(r_p1);
        end
        w_rnd = rnd_shr(w_sum, 6'(TRIG_SHIFT));
        n_res = w_rnd[ROT_W-1:0];
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // Hold the data stages
    always_ff @(posedge i_clk) begin
        r_p0  <= n_p0;
        r_p1  <= n_p1;
        r_sub <= i_sub;
        r_res <= n_res;
    end

    assign o_vld = r_vld2;
    assign o_res = r_res;

endmodule

>>> rtl/rotate_project_point_core.sv
// Rotates a point by yaw, tilt and roll, then scales and centres it on the screen.
// The result is taken at the o_strobe edge, after the three two-stage rotation steps
// (yaw, tilt, roll) and the two-stage pixel stage in series.
// Throughput: one transaction per clock; busy stays low.
// Reset (synchronous, active low) empties the pipeline and restores identity trig, scale 1.0.
// The receiver cannot stall: each result is valid on o_result only while o_strobe is high, for a single cycle.
module rotate_project_point_core
    import rpp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 240
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_point        i_point,
    output logic          o_strobe,
    output t_screen       o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam logic signed [PIX_W-1:0] HALF_W = PIX_W'(SCREEN_WIDTH / 2);
    localparam logic signed [PIX_W-1:0] HALF_H = PIX_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [PIX_W-1:0] LIM_W  = PIX_W'(SCREEN_WIDTH);
    localparam logic signed [PIX_W-1:0] LIM_H  = PIX_W'(SCREEN_HEIGHT);
    localparam int PPROD_W = ROT_W + SCALE_W + 1;

    // Configuration registers
    logic signed [TRIG_W-1:0] r_cos_yaw;
    logic signed [TRIG_W-1:0] r_sin_yaw;
    logic signed [TRIG_W-1:0] r_cos_tilt;
    logic signed [TRIG_W-1:0] r_sin_tilt;
    logic signed [TRIG_W-1:0] r_cos_roll;
    logic signed [TRIG_W-1:0] r_sin_roll;
    logic [SCALE_W-1:0]       r_pixel_scale;
    logic                     w_wr;
    logic [2:0]               w_idx;

    // Datapath
    logic                     w_acc;
    logic signed [ROT_W-1:0]  w_x;
    logic signed [ROT_W-1:0]  w_y;
    logic signed [ROT_W-1:0]  w_z;
    logic signed [ROT_W-1:0]  r_y_d1;
    logic signed [ROT_W-1:0]  r_y_d2;
    logic                     w_v1;
    logic                     w_v1b;
    logic signed [ROT_W-1:0]  w_rx1;
    logic signed [ROT_W-1:0]  w_rz1;
    logic signed [ROT_W-1:0]  r_rx1_d1;
    logic signed [ROT_W-1:0]  r_rx1_d2;
    logic                     w_v2;
    logic signed [ROT_W-1:0]  w_ry2;
    logic                     w_v3;
    logic                     w_v3b;
    logic signed [ROT_W-1:0]  w_rx3;
    logic signed [ROT_W-1:0]  w_ry3;
    logic signed [SCALE_W:0]  w_scale;
    logic signed [PPROD_W-1:0] r_ox_p;
    logic signed [PPROD_W-1:0] r_oy_p;
    logic signed [PPROD_W-1:0] n_ox_p;
    logic signed [PPROD_W-1:0] n_oy_p;
    logic                     r_pv;
    logic signed [WIDE_W-1:0] w_ox;
    logic signed [WIDE_W-1:0] w_oy;
    logic signed [PIX_W-1:0]  w_px;
    logic signed [PIX_W-1:0]  w_py;
    logic                     w_on;
    t_screen                  n_out;
    t_screen                  r_out;
    logic                     r_strobe;

    // APB write decode; pready is always high
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_yaw     <= TRIG_ONE;
            r_sin_yaw     <= '0;
            r_cos_tilt    <= TRIG_ONE;
            r_sin_tilt    <= '0;
            r_cos_roll    <= TRIG_ONE;
            r_sin_roll    <= '0;
            r_pixel_scale <= SCALE_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_COS_YAW:     r_cos_yaw     <= pwdata[TRIG_W-1:0];
                REG_SIN_YAW:     r_sin_yaw     <= pwdata[TRIG_W-1:0];
                REG_COS_TILT:    r_cos_tilt    <= pwdata[TRIG_W-1:0];
                REG_SIN_TILT:    r_sin_tilt    <= pwdata[TRIG_W-1:0];
                REG_COS_ROLL:    r_cos_roll    <= pwdata[TRIG_W-1:0];
                REG_SIN_ROLL:    r_sin_roll    <= pwdata[TRIG_W-1:0];
                REG_PIXEL_SCALE: r_pixel_scale <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // APB read mux
    always_comb begin
        case (w_idx)
            REG_COS_YAW:     prdata = {16'd0, r_cos_yaw};
            REG_SIN_YAW:     prdata = {16'd0, r_sin_yaw};
            REG_COS_TILT:    prdata = {16'd0, r_cos_tilt};
            REG_SIN_TILT:    prdata = {16'd0, r_sin_tilt};
            REG_COS_ROLL:    prdata = {16'd0, r_cos_roll};
            REG_SIN_ROLL:    prdata = {16'd0, r_sin_roll};
            REG_PIXEL_SCALE: prdata = {16'd0, r_pixel_scale};
            default:         prdata = 32'd0;
        endcase
    end

    // Accept a transaction every cycle
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;
    assign w_x   = ROT_W'(i_point.point_x);
    assign w_y   = ROT_W'(i_point.point_y);
    assign w_z   = ROT_W'(i_point.point_z);

    // Yaw: turn the x/z plane
    rpp_rot u_rot_rx1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_sub   (1'b0),
        .i_a     (w_x),
        .i_b     (r_cos_yaw),
        .i_c     (w_z),
        .i_d     (r_sin_yaw),
        .o_vld   (w_v1),
        .o_res   (w_rx1)
    );

    rpp_rot u_rot_rz1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_acc),
        .i_sub   (1'b1),
        .i_a     (w_z),
        .i_b     (r_cos_yaw),
        .i_c     (w_x),
        .i_d     (r_sin_yaw),
        .o_vld   (w_v1b),
        .o_res   (w_rz1)
    );

    // Delay y to meet the yaw results, and rx1 to meet the tilt result
    always_ff @(posedge i_clk) begin
        r_y_d1   <= w_y;
        r_y_d2   <= r_y_d1;
        r_rx1_d1 <= w_rx1;
        r_rx1_d2 <= r_rx1_d1;
    end

    // Tilt: turn the y/z plane
    rpp_rot u_rot_ry2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_v1 & w_v1b),
        .i_sub   (1'b1),
        .i_a     (r_y_d2),
        .i_b     (r_cos_tilt),
        .i_c     (w_rz1),
        .i_d     (r_sin_tilt),
        .o_vld   (w_v2),
        .o_res   (w_ry2)
    );

    // Roll: turn the x/y plane
    rpp_rot u_rot_rx3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_v2),
        .i_sub   (1'b1),
        .i_a     (r_rx1_d2),
        .i_b     (r_cos_roll),
        .i_c     (w_ry2),
        .i_d     (r_sin_roll),
        .o_vld   (w_v3),
        .o_res   (w_rx3)
    );

    rpp_rot u_rot_ry3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_v2),
        .i_sub   (1'b0),
        .i_a     (r_rx1_d2),
        .i_b     (r_sin_roll),
        .i_c     (w_ry2),
        .i_d     (r_cos_roll),
        .o_vld   (w_v3b),
        .o_res   (w_ry3)
    );

    // Scale to pixels
    assign w_scale = $signed({1'b0, r_pixel_scale});
    assign n_ox_p  = w_rx3 * w_scale;
    assign n_oy_p  = w_ry3 * w_scale;

    // Round, centre, flip y and clip to the screen
    always_comb begin
        w_ox = rnd_shr(WIDE_W'(r_ox_p), 6'(PIX_SHIFT));
        w_oy = rnd_shr(WIDE_W'(r_oy_p), 6'(PIX_SHIFT));
        w_px = HALF_W + w_ox[PIX_W-1:0];
        w_py = HALF_H - w_oy[PIX_W-1:0];
        w_on = (w_px >= 0) && (w_px < LIM_W) && (w_py >= 0) && (w_py < LIM_H);
        if (w_on) begin
            n_out.screen_x = w_px[PIXEL_W-1:0];
            n_out.screen_y = w_py[PIXEL_W-1:0];
            n_out.visible  = 1'b1;
        end else begin
            n_out.screen_x = '0;
            n_out.screen_y = '0;
            n_out.visible  = 1'b0;
        end
    end

    // Advance the pixel stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pv     <= w_v3 & w_v3b;
            r_strobe <= r_pv;
        end
    end

    // Hold the pixel stage data
    always_ff @(posedge i_clk) begin
        r_ox_p <= n_ox_p;
        r_oy_p <= n_oy_p;
        r_out  <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

>>> tb/sv/tb_rotate_project_point_core.sv
module tb_rotate_project_point_core;
    import rpp_pkg::*;

    localparam int SCR_W       = 240;
    localparam int SCR_H       = 240;
    localparam int NUM_REGS    = 7;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 115;

    // Index past the register file, used to show that such writes are dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_point      i_point = '0;
    logic        o_strobe;
    t_screen     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the register file
    logic [15:0] cfg_regs [NUM_REGS];

    t_screen pending_screens [$];
    int      err_cnt   = 0;
    int      cycle_cnt = 0;

    // One row of the directed table: a register write or a point
    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [15:0] val;
        t_point      pt;
        bit          typed;
        t_screen     res;
    } t_row;

    t_row dir_rows [$];

    rotate_project_point_core #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_point  (i_point),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Divide by 2^s, rounding half away from zero
    function automatic longint round_away(longint v, int s);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q   = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -q : q;
    endfunction

    // Rotate, scale and centre one point under the current register copy
    function automatic t_screen project_point(t_point p);
        longint  x, y, z, c_yaw, s_yaw, c_tilt, s_tilt, c_roll, s_roll, scale;
        longint  rx1, rz1, ry2, rx3, ry3, px, py;
        t_screen r;
        x      = longint'(p.point_x);
        y      = longint'(p.point_y);
        z      = longint'(p.point_z);
        c_yaw  = longint'($signed(cfg_regs[REG_COS_YAW]));
        s_yaw  = longint'($signed(cfg_regs[REG_SIN_YAW]));
        c_tilt = longint'($signed(cfg_regs[REG_COS_TILT]));
        s_tilt = longint'($signed(cfg_regs[REG_SIN_TILT]));
        c_roll = longint'($signed(cfg_regs[REG_COS_ROLL]));
        s_roll = longint'($signed(cfg_regs[REG_SIN_ROLL]));
        scale  = longint'(cfg_regs[REG_PIXEL_SCALE]);
        rx1 = round_away(x * c_yaw + z * s_yaw, TRIG_SHIFT);
        rz1 = round_away(z * c_yaw - x * s_yaw, TRIG_SHIFT);
        ry2 = round_away(y * c_tilt - rz1 * s_tilt, TRIG_SHIFT);
        rx3 = round_away(rx1 * c_roll - ry2 * s_roll, TRIG_SHIFT);
        ry3 = round_away(rx1 * s_roll + ry2 * c_roll, TRIG_SHIFT);
        px  = longint'(SCR_W / 2) + round_away(rx3 * scale, PIX_SHIFT);
        py  = longint'(SCR_H / 2) - round_away(ry3 * scale, PIX_SHIFT);
        r = '0;
        if (px >= 0 && px < SCR_W && py >= 0 && py < SCR_H) begin
            r.screen_x = px[7:0];
            r.screen_y = py[7:0];
            r.visible  = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($signed($urandom_range(0, 8191)) - 4096);
            2: v = 16'($signed($urandom_range(0, 1023)) - 512);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = 16'sh0000;
                    default: v = -16'sd1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_trig();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h4000;
                    1: v = 16'hc000;
                    2: v = 16'h0000;
                    3: v = 16'h7fff;
                    default: v = 16'h8000;
                endcase
            end
            1: v = 16'($urandom);
            default: v = 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_scale();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'h0000;
            1: v = 16'hffff;
            2: v = 16'($urandom);
            default: v = 16'($urandom_range(64, 16'h1000));
        endcase
        return v;
    endfunction

    task automatic add_cfg(input logic [2:0] idx, input logic [15:0] val);
        t_row r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        dir_rows.push_back(r);
    endtask

    task automatic add_pt(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z);
        t_row r;
        r    = '{default: '0};
        r.pt = '{point_x: x, point_y: y, point_z: z};
        dir_rows.push_back(r);
    endtask

    task automatic add_pt_res(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z, input logic [7:0] sx,
                              input logic [7:0] sy, input logic vis);
        t_row r;
        r       = '{default: '0};
        r.pt    = '{point_x: x, point_y: y, point_z: z};
        r.typed = 1'b1;
        r.res   = '{screen_x: sx, screen_y: sy, visible: vis};
        dir_rows.push_back(r);
    endtask

    // Offer one transaction and hold it until accepted
    task automatic send_point(input t_point p, input t_screen want);
        start   <= 1'b1;
        i_point <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_screens.push_back(want);
    endtask

    task automatic idle_gap(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drop start and wait for every pending result
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_screens.size() != 0);
    endtask

    // One register transaction: setup phase, access phase, then back to idle
    task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [15:0] val,
                            output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        if (wr && idx < NUM_REGS) cfg_regs[idx] = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Read back every register and compare with the predictor copy
    task automatic check_regs();
        logic [31:0] rd;
        for (int i = 0; i < NUM_REGS; i++) begin
            apb_xfer(1'b0, 3'(i), 16'h0000, rd);
            if (rd[15:0] !== cfg_regs[i]) begin
                $error("reg %0d: expected %0h, actual %0h", i, cfg_regs[i], rd[15:0]);
                err_cnt++;
            end
        end
    endtask

    // Compare each strobed result with the oldest pending one
    always @(posedge i_clk) begin
        t_screen want;
        if (i_rst_n && o_strobe) begin
            if (pending_screens.size() == 0) begin
                $error("result with no transaction pending");
                err_cnt++;
            end else begin
                want = pending_screens.pop_front();
                if (o_result.screen_x !== want.screen_x) begin
                    $error("screen_x: expected %0d, actual %0d",
                           want.screen_x, o_result.screen_x);
                    err_cnt++;
                end
                if (o_result.screen_y !== want.screen_y) begin
                    $error("screen_y: expected %0d, actual %0d",
                           want.screen_y, o_result.screen_y);
                    err_cnt++;
                end
                if (o_result.visible !== want.visible) begin
                    $error("visible: expected %0d, actual %0d",
                           want.visible, o_result.visible);
                    err_cnt++;
                end
            end
        end
    end

    // Guard the whole run
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [31:0] rd;
        t_point      p;
        t_screen     want;
        int          burst_left;
        bit          no_idle;

        cfg_regs[REG_COS_YAW]     = TRIG_ONE;
        cfg_regs[REG_SIN_YAW]     = '0;
        cfg_regs[REG_COS_TILT]    = TRIG_ONE;
        cfg_regs[REG_SIN_TILT]    = '0;
        cfg_regs[REG_COS_ROLL]    = TRIG_ONE;
        cfg_regs[REG_SIN_ROLL]    = '0;
        cfg_regs[REG_PIXEL_SCALE] = SCALE_RESET;

        // Identity rotation at unit scale: offset is the coordinate in whole units
        add_pt_res(16'sd0, 16'sd0, 16'sd0, 8'd120, 8'd120, 1'b1);
        add_pt_res(16'sd32767, 16'sd0, 16'sd0, 8'd136, 8'd120, 1'b1);
        add_pt_res(-16'sd32768, 16'sd0, 16'sd0, 8'd104, 8'd120, 1'b1);
        add_pt_res(16'sd0, 16'sd32767, 16'sd0, 8'd120, 8'd104, 1'b1);
        add_pt_res(16'sd0, -16'sd32768, 16'sd0, 8'd120, 8'd136, 1'b1);
        add_pt_res(16'sd0, 16'sd0, 16'sd32767, 8'd120, 8'd120, 1'b1);
        // Exact halves round away from zero, just under half rounds towards it
        add_pt_res(16'sd1024, -16'sd1024, 16'sd5, 8'd121, 8'd121, 1'b1);
        add_pt_res(-16'sd1024, 16'sd1024, 16'sd0, 8'd119, 8'd119, 1'b1);
        add_pt_res(16'sd1023, -16'sd1023, 16'sd0, 8'd120, 8'd120, 1'b1);
        // Scale 16.0: one pixel per 128 counts, probe the screen edges
        add_cfg(REG_PIXEL_SCALE, 16'h1000);
        add_pt_res(16'sd15232, 16'sd0, 16'sd0, 8'd239, 8'd120, 1'b1);
        add_pt_res(16'sd15295, 16'sd0, 16'sd0, 8'd239, 8'd120, 1'b1);
        add_pt_res(16'sd15296, 16'sd0, 16'sd0, 8'd0, 8'd0, 1'b0);
        add_pt_res(-16'sd15360, 16'sd0, 16'sd0, 8'd0, 8'd120, 1'b1);
        add_pt_res(-16'sd15423, 16'sd0, 16'sd0, 8'd0, 8'd120, 1'b1);
        add_pt_res(-16'sd15424, 16'sd0, 16'sd0, 8'd0, 8'd0, 1'b0);
        add_pt_res(16'sd0, 16'sd15360, 16'sd0, 8'd120, 8'd0, 1'b1);
        add_pt_res(16'sd0, 16'sd15424, 16'sd0, 8'd0, 8'd0, 1'b0);
        add_pt_res(16'sd0, -16'sd15232, 16'sd0, 8'd120, 8'd239, 1'b1);
        add_pt_res(16'sd0, -16'sd15296, 16'sd0, 8'd0, 8'd0, 1'b0);
        // Zero scale pins every point to the centre
        add_cfg(REG_PIXEL_SCALE, 16'h0000);
        add_pt_res(16'sd32767, -16'sd32768, 16'sd32767, 8'd120, 8'd120, 1'b1);
        // Full scale throws one unit far off screen
        add_cfg(REG_PIXEL_SCALE, 16'hffff);
        add_pt_res(16'sd2048, 16'sd0, 16'sd0, 8'd0, 8'd0, 1'b0);
        add_pt_res(16'sd0, 16'sd0, 16'sd0, 8'd120, 8'd120, 1'b1);
        // Trig values outside the nominal range, and a write past the register file
        add_cfg(REG_COS_YAW, 16'h8000);
        add_cfg(REG_SIN_YAW, 16'h8000);
        add_cfg(REG_COS_TILT, 16'h7fff);
        add_cfg(REG_SIN_TILT, 16'h8000);
        add_cfg(REG_COS_ROLL, 16'h8000);
        add_cfg(REG_SIN_ROLL, 16'h7fff);
        add_cfg(REG_PIXEL_SCALE, 16'h0100);
        add_cfg(REG_UNUSED, 16'hffff);
        add_pt(16'sd32767, -16'sd32768, 16'sd32767);
        add_pt(-16'sd32768, 16'sd32767, -16'sd32768);
        add_pt(16'sd12345, -16'sd2222, 16'sd777);

        // Hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_regs();

        // Walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                apb_xfer(1'b1, dir_rows[i].idx, dir_rows[i].val, rd);
            end else begin
                want = dir_rows[i].typed ? dir_rows[i].res : project_point(dir_rows[i].pt);
                send_point(dir_rows[i].pt, want);
                if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
            end
        end
        drain();
        check_regs();

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            for (int r = 0; r < NUM_REGS; r++) begin
                apb_xfer(1'b1, 3'(r), (r == REG_PIXEL_SCALE) ? rand_scale() : rand_trig(), rd);
            end
            if ($urandom_range(0, 2) == 0) apb_xfer(1'b1, REG_UNUSED, 16'($urandom), rd);
            check_regs();
            no_idle    = (ph == 2);
            burst_left = $urandom_range(1, 40);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Stop offering until the pipeline is empty
                if (ph == 5 && n == PHASE_ITEMS / 2) drain();
                p.point_x = rand_coord();
                p.point_y = rand_coord();
                p.point_z = rand_coord();
                send_point(p, project_point(p));
                burst_left--;
                if (!no_idle && burst_left == 0) begin
                    idle_gap(($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 6));
                    burst_left = $urandom_range(1, 40);
                end
            end
        end

        // Let the pipeline empty, then settle
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> rotate_project_point_core.f
rtl/rpp_pkg.sv
rtl/rpp_rot.sv
rtl/rotate_project_point_core.sv
tb/sv/tb_rotate_project_point_core.sv
